FILE: rtl/ndef_record_header_parser_defines.svh
// ----------------------------------------------------------------------------
// NDEF record header parser assertion macros
// Shared concurrent assertion shorthands, clocked on clk, held off in reset.
// ----------------------------------------------------------------------------
`ifndef NDEF_RECORD_HEADER_PARSER_DEFINES_SVH
`define NDEF_RECORD_HEADER_PARSER_DEFINES_SVH

// Same-cycle implication.
`define NRHP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nrhp assertion failed");

// Next-cycle implication.
`define NRHP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nrhp assertion failed");

`endif

FILE: rtl/nrhp_pkg.sv
// ----------------------------------------------------------------------------
// NDEF record header parser package
// Payload types, header flag codes, parse phases and register indexes.
// ----------------------------------------------------------------------------
package nrhp_pkg;

  localparam int MAX_TYPE_BYTES = 16;
  localparam int MAX_MSG_BYTES  = 4096;
  localparam int CNT_W          = $clog2(MAX_MSG_BYTES + 1);
  localparam int LEN_W          = CNT_W + 1;

  // Record header flag fields
  localparam logic [7:0] FLAG_TNF_MASK = 8'h07;
  localparam logic [7:0] TNF_EXTERNAL  = 8'h04;
  localparam int         FLAG_SR_BIT   = 4;
  localparam int         FLAG_IL_BIT   = 3;

  typedef enum logic [7:0] {
    PH_FLAGS  = 8'b0000_0001,
    PH_TLEN   = 8'b0000_0010,
    PH_PLEN   = 8'b0000_0100,
    PH_IDLEN  = 8'b0000_1000,
    PH_IDSKIP = 8'b0001_0000,
    PH_TYPE   = 8'b0010_0000,
    PH_PAY    = 8'b0100_0000,
    PH_TAIL   = 8'b1000_0000
  } phase_t;

  typedef enum logic [1:0] {
    CFG_EXP_TYPE_LEN = 2'd0,
    CFG_TYPE_LOW     = 2'd1,
    CFG_TYPE_HIGH    = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic        accepted;
    logic [7:0]  command;
    logic [31:0] payload_length;
    logic [12:0] payload_offset;
  } out_t;

endpackage

FILE: rtl/ndef_record_header_parser.sv
// ----------------------------------------------------------------------------
// NDEF record header parser
// Parses the first record header of a byte-streamed NDEF message and checks
// it against a configured external type.
// ----------------------------------------------------------------------------
// Feed one message byte per transaction, with last_byte set on the final one.
// The block takes a byte every cycle unless a last byte waits for output
// space; each byte is registered, then parsed by one phase-update stage, and
// on the last byte the verdict is loaded into the output register when that
// byte is parsed. Only the last byte waits for output space, so a stalled result
// does not hold back the bytes of the next message. One result transaction
// comes out per message: accepted with command (first payload byte), payload
// length and payload offset, or all zeros when the message is rejected.
// Program the type registers only while no message is in flight.
module ndef_record_header_parser (
  input  logic               clk,
  input  logic               rst_n,
  // byte stream
  input  logic               in_valid,
  output logic               in_stall,
  input  nrhp_pkg::in_t      in_data,
  // verdict
  output logic               out_valid,
  input  logic               out_stall,
  output nrhp_pkg::out_t     out_data,
  // configuration
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_wdata
);
  import nrhp_pkg::*;

  // configuration registers
  logic [4:0]                        exp_tlen_r;
  logic [MAX_TYPE_BYTES-1:0][7:0]    type_tbl_r;

  // input register
  logic s1_valid_r;
  in_t  s1_data_r;

  // message parse state
  phase_t           phase_r,     phase_nxt;
  logic [CNT_W-1:0] count_r,     count_nxt;
  logic [7:0]       flags_r,     flags_nxt;
  logic [7:0]       tlen_r,      tlen_nxt;
  logic [31:0]      psize_r,     psize_nxt;
  logic [8:0]       hdr_r,       hdr_nxt;
  logic [7:0]       first_pay_r, first_pay_nxt;
  logic             mismatch_r,  mismatch_nxt;
  logic             overflow_r,  overflow_nxt;

  // output register
  logic out_valid_r;
  out_t out_data_r, result;

  logic             out_free, fire;
  logic [7:0]       b;
  logic [LEN_W-1:0] msg_len, base_len;
  logic [CNT_W-1:0] type_idx;
  logic [33:0]      need_len;
  logic             ok;

  assign out_free  = !out_valid_r || !out_stall;
  // a non-final byte never needs output space
  assign fire      = s1_valid_r && (!s1_data_r.last_byte || out_free);
  assign in_stall  = s1_valid_r && !fire;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign b         = s1_data_r.msg_byte;
  assign msg_len   = LEN_W'(count_r) + LEN_W'(1);
  assign type_idx  = count_r - CNT_W'(hdr_r);

  // parse one byte and form the verdict
  always_comb begin
    phase_nxt     = phase_r;
    count_nxt     = count_r;
    flags_nxt     = flags_r;
    tlen_nxt      = tlen_r;
    psize_nxt     = psize_r;
    hdr_nxt       = hdr_r;
    first_pay_nxt = first_pay_r;
    mismatch_nxt  = mismatch_r;
    overflow_nxt  = overflow_r;

    if (count_r >= CNT_W'(MAX_MSG_BYTES)) begin
      // drop bytes past the size limit, remember the overflow
      overflow_nxt = 1'b1;
    end else begin
      count_nxt = count_r + CNT_W'(1);
      unique case (phase_r)
        PH_FLAGS: begin
          flags_nxt = b;
          phase_nxt = PH_TLEN;
        end
        PH_TLEN: begin
          tlen_nxt  = b;
          psize_nxt = '0;
          phase_nxt = PH_PLEN;
        end
        PH_PLEN: begin
          if (flags_r[FLAG_SR_BIT]) begin
            psize_nxt = {24'd0, b};
          end else begin
            psize_nxt = {psize_r[23:0], b};
          end
          if (flags_r[FLAG_SR_BIT] || count_r >= CNT_W'(5)) begin
            hdr_nxt = count_r[8:0] + 9'd1;
            if (flags_r[FLAG_IL_BIT]) begin
              phase_nxt = PH_IDLEN;
            end else begin
              phase_nxt = (tlen_r != 8'd0) ? PH_TYPE : PH_PAY;
            end
          end
        end
        PH_IDLEN: begin
          hdr_nxt = hdr_r + 9'd1 + {1'b0, b};
          if (b != 8'd0) begin
            phase_nxt = PH_IDSKIP;
          end else begin
            phase_nxt = (tlen_r != 8'd0) ? PH_TYPE : PH_PAY;
          end
        end
        PH_IDSKIP: begin
          if (msg_len >= LEN_W'(hdr_r)) begin
            phase_nxt = (tlen_r != 8'd0) ? PH_TYPE : PH_PAY;
          end
        end
        PH_TYPE: begin
          if (type_idx >= CNT_W'(MAX_TYPE_BYTES) ||
              type_tbl_r[type_idx[3:0]] != b) begin
            mismatch_nxt = 1'b1;
          end
          if (LEN_W'(type_idx) + LEN_W'(1) >= LEN_W'(tlen_r)) begin
            phase_nxt = PH_PAY;
          end
        end
        PH_PAY: begin
          first_pay_nxt = b;
          phase_nxt     = PH_TAIL;
        end
        default: begin
        end
      endcase
    end

    // verdict on the updated header fields
    base_len = flags_nxt[FLAG_SR_BIT] ? LEN_W'(3) : LEN_W'(6);
    need_len = 34'(hdr_nxt) + 34'(tlen_nxt) + 34'(psize_nxt);
    ok = !overflow_nxt;
    if (msg_len < LEN_W'(3))                                  ok = 1'b0;
    if ((flags_nxt & FLAG_TNF_MASK) != TNF_EXTERNAL)          ok = 1'b0;
    if (msg_len < base_len)                                   ok = 1'b0;
    if (flags_nxt[FLAG_IL_BIT] && msg_len < base_len + LEN_W'(1)) ok = 1'b0;
    if (need_len > 34'(msg_len))                              ok = 1'b0;
    if (tlen_nxt != {3'd0, exp_tlen_r})                       ok = 1'b0;
    if (mismatch_nxt)                                         ok = 1'b0;
    if (psize_nxt == 32'd0)                                   ok = 1'b0;

    result = '0;
    if (ok) begin
      result.accepted       = 1'b1;
      result.command        = first_pay_nxt;
      result.payload_length = psize_nxt;
      result.payload_offset = 13'({1'b0, hdr_nxt} + {2'b0, tlen_nxt});
    end

    // end of message: start over for the next one
    if (s1_data_r.last_byte) begin
      phase_nxt     = PH_FLAGS;
      count_nxt     = '0;
      flags_nxt     = '0;
      tlen_nxt      = '0;
      psize_nxt     = '0;
      hdr_nxt       = '0;
      first_pay_nxt = '0;
      mismatch_nxt  = 1'b0;
      overflow_nxt  = 1'b0;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_tlen_r <= '0;
      type_tbl_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_EXP_TYPE_LEN: exp_tlen_r       <= cfg_wdata[4:0];
        CFG_TYPE_LOW:     type_tbl_r[7:0]  <= cfg_wdata;
        CFG_TYPE_HIGH:    type_tbl_r[15:8] <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // input register: take a byte when empty or when the parse stage moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid_r <= 1'b1;
    end else if (fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r <= in_data;
    end
  end

  // parse state: advance on every parsed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_FLAGS;
      count_r     <= '0;
      flags_r     <= '0;
      tlen_r      <= '0;
      psize_r     <= '0;
      hdr_r       <= '0;
      first_pay_r <= '0;
      mismatch_r  <= 1'b0;
      overflow_r  <= 1'b0;
    end else if (fire) begin
      phase_r     <= phase_nxt;
      count_r     <= count_nxt;
      flags_r     <= flags_nxt;
      tlen_r      <= tlen_nxt;
      psize_r     <= psize_nxt;
      hdr_r       <= hdr_nxt;
      first_pay_r <= first_pay_nxt;
      mismatch_r  <= mismatch_nxt;
      overflow_r  <= overflow_nxt;
    end
  end

  // output register: load the verdict, hold it until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && s1_data_r.last_byte) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && s1_data_r.last_byte) begin
      out_data_r <= result;
    end
  end

endmodule

FILE: rtl/nrhp_checker.sv
// ----------------------------------------------------------------------------
// NDEF record header parser checker
// Port-level assertions on the parser, bound into the parser module.
// ----------------------------------------------------------------------------
`include "ndef_record_header_parser_defines.svh"

module nrhp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input nrhp_pkg::out_t     out_data
);
  import nrhp_pkg::*;

  logic        reject_clean;
  logic [32:0] accept_end;
  logic        accept_fits;

  assign reject_clean = out_data.command == 8'd0 && out_data.payload_length == 32'd0 &&
                        out_data.payload_offset == 13'd0;
  assign accept_end   = 33'(out_data.payload_offset) + 33'(out_data.payload_length);
  assign accept_fits  = out_data.payload_length != 32'd0 && out_data.payload_offset >= 13'd3 &&
                        accept_end <= 33'(MAX_MSG_BYTES);

  // hold a stalled verdict
  `NRHP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // a rejected message reports all zeros
  `NRHP_ASSERT_NOW(a_reject_zero, out_valid && !out_data.accepted, reject_clean)

  // an accepted record has a payload that fits in a message of legal size
  `NRHP_ASSERT_NOW(a_accept_fits, out_valid && out_data.accepted, accept_fits)

  // with the output register empty, the byte stream never stalls
  `NRHP_ASSERT_NOW(a_no_idle_stall, in_valid && !out_valid, !in_stall)

endmodule

bind ndef_record_header_parser nrhp_checker u_nrhp_checker (.*);

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// NDEF record header parser testbench
// Streams NDEF messages into the parser byte by byte under bursty input and a
// patterned output stall. A built-in parser model predicts each verdict, and
// the scoreboard checks it field by field against the block's result.
// ----------------------------------------------------------------------------
module tb_top;
  import nrhp_pkg::*;

  // Cycles without any transaction before the run is declared hung.
  localparam int QUIET_LIMIT = 1000;
  // Random input bytes per register setting.
  localparam int PHASE_BYTES = 140;
  localparam int NUM_PHASES  = 6;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_BLOCKS,
    STALL_SPARSE
  } stall_mode_t;

  // --------------------------------------------------------------------------
  // Verdict scoreboard: a byte-level copy of the parser plus the queue of
  // verdicts that the block still owes.
  // --------------------------------------------------------------------------
  class verdict_board;
    logic [4:0]  want_tlen;
    logic [63:0] want_type_lo;
    logic [63:0] want_type_hi;

    phase_t      ph;
    logic [12:0] nbytes;
    logic [7:0]  flags;
    logic [7:0]  tlen;
    logic [31:0] psize;
    logic [8:0]  hdr_len;
    logic [7:0]  first_pay;
    logic        type_bad;
    logic        too_long;

    out_t        verdicts[$];
    int          errors;

    function new();
      want_tlen    = '0;
      want_type_lo = '0;
      want_type_hi = '0;
      errors       = 0;
      restart();
    endfunction

    function void restart();
      ph        = PH_FLAGS;
      nbytes    = '0;
      flags     = '0;
      tlen      = '0;
      psize     = '0;
      hdr_len   = '0;
      first_pay = '0;
      type_bad  = 1'b0;
      too_long  = 1'b0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [63:0] value);
      case (idx)
        CFG_EXP_TYPE_LEN: want_tlen    = value[4:0];
        CFG_TYPE_LOW:     want_type_lo = value;
        CFG_TYPE_HIGH:    want_type_hi = value;
        default: ;
      endcase
    endfunction

    function logic [7:0] type_byte(int unsigned k);
      if (k < 8) return want_type_lo[8 * k[2:0] +: 8];
      return want_type_hi[8 * k[2:0] +: 8];
    endfunction

    function void enter_type();
      ph = (tlen != 8'd0) ? PH_TYPE : PH_PAY;
    endfunction

    function void parse(logic [12:0] i, logic [7:0] b);
      int unsigned k;
      case (ph)
        PH_FLAGS: begin
          flags = b;
          ph    = PH_TLEN;
        end
        PH_TLEN: begin
          tlen  = b;
          psize = '0;
          ph    = PH_PLEN;
        end
        PH_PLEN: begin
          psize = flags[FLAG_SR_BIT] ? {24'd0, b} : {psize[23:0], b};
          if (flags[FLAG_SR_BIT] || i >= 13'd5) begin
            hdr_len = 9'(i + 13'd1);
            if (flags[FLAG_IL_BIT]) ph = PH_IDLEN;
            else enter_type();
          end
        end
        PH_IDLEN: begin
          hdr_len = 9'(hdr_len + 9'd1 + {1'b0, b});
          if (b != 8'd0) ph = PH_IDSKIP;
          else enter_type();
        end
        PH_IDSKIP: begin
          if (32'(i) + 1 >= 32'(hdr_len)) enter_type();
        end
        PH_TYPE: begin
          k = 32'(i) - 32'(hdr_len);
          if (k >= MAX_TYPE_BYTES || type_byte(k) != b) type_bad = 1'b1;
          if (k + 1 >= 32'(tlen)) ph = PH_PAY;
        end
        PH_PAY: begin
          first_pay = b;
          ph        = PH_TAIL;
        end
        default: ;
      endcase
    endfunction

    // Note an accepted input byte; queue a verdict when it ends a message.
    function void absorb(in_t item);
      logic [12:0] i;
      int unsigned len;
      int unsigned base;
      bit          ok;
      out_t        v;
      i = nbytes;
      if (i >= MAX_MSG_BYTES) too_long = 1'b1;
      else begin
        parse(i, item.msg_byte);
        nbytes = i + 13'd1;
      end
      if (!item.last_byte) return;

      len  = 32'(i) + 1;
      base = flags[FLAG_SR_BIT] ? 3 : 6;
      ok   = !too_long;
      if (len < 3) ok = 1'b0;
      if ((flags & FLAG_TNF_MASK) != TNF_EXTERNAL) ok = 1'b0;
      if (len < base) ok = 1'b0;
      if (flags[FLAG_IL_BIT] && len < base + 1) ok = 1'b0;
      if (ok && 64'(hdr_len) + 64'(tlen) + 64'(psize) > 64'(len)) ok = 1'b0;
      if (tlen != {3'b000, want_tlen}) ok = 1'b0;
      if (type_bad) ok = 1'b0;
      if (psize == 32'd0) ok = 1'b0;

      v = '0;
      if (ok) begin
        v.accepted       = 1'b1;
        v.command        = first_pay;
        v.payload_length = psize;
        v.payload_offset = 13'(32'(hdr_len) + 32'(tlen));
      end
      verdicts.push_back(v);
      restart();
    endfunction

    function void compare(string field, logic [31:0] exp_v, logic [31:0] got_v);
      if (got_v !== exp_v) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, got_v);
        errors++;
      end
    endfunction

    // Check one accepted result transaction against the oldest verdict.
    function void check(out_t got);
      out_t e;
      if (verdicts.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h", $time, got);
        errors++;
        return;
      end
      e = verdicts.pop_front();
      compare("accepted", 32'(e.accepted), 32'(got.accepted));
      compare("command", 32'(e.command), 32'(got.command));
      compare("payload_length", e.payload_length, got.payload_length);
      compare("payload_offset", 32'(e.payload_offset), 32'(got.payload_offset));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block ports
  // --------------------------------------------------------------------------
  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_t         in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = CFG_EXP_TYPE_LEN;
  logic [63:0] cfg_wdata = '0;

  verdict_board board = new();

  logic [7:0]  rec_bytes[$];   // message being built, sent in order
  int unsigned burst_left = 0;
  bit          steady     = 1'b0;
  int unsigned quiet      = 0;
  logic [7:0]  stall_cyc  = '0;
  stall_mode_t stall_mode = STALL_NONE;

  always #5 clk = ~clk;

  ndef_record_header_parser uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Result side: stall on a randomly chosen pattern, from no stall at all to
  // long blocks of stall, then check each accepted result.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    stall_cyc <= stall_cyc + 8'd1;
    if (stall_cyc[6:0] == 7'd0) stall_mode <= stall_mode_t'($urandom_range(0, 3));
    case (stall_mode)
      STALL_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
      STALL_BLOCKS: out_stall <= (stall_cyc[3:0] < 4'd11);
      STALL_SPARSE: out_stall <= ($urandom_range(0, 9) == 0);
      default:      out_stall <= 1'b0;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check(out_data);
  end

  // Watchdog: count cycles in which no transaction happens on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet == QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Drive one byte and hold it until the block takes it. Between bursts drop
  // valid for a random gap, unless this stretch runs steady.
  task automatic send_byte(logic [7:0] b, bit fin);
    in_t         item;
    int unsigned gap;
    item.msg_byte  = b;
    item.last_byte = fin;
    if (burst_left == 0) begin
      gap        = steady ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.absorb(item);
  endtask

  // Send the built message, marking its final byte.
  task automatic send_frame();
    for (int n = 0; n < rec_bytes.size(); n++) begin
      send_byte(rec_bytes[n], n == rec_bytes.size() - 1);
    end
    rec_bytes.delete();
  endtask

  // Drop valid, wait for every owed verdict, then let the block finish its
  // pipeline before the registers change.
  task automatic settle();
    in_valid <= 1'b0;
    while (board.verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [63:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    board.set_reg(idx, value);
  endtask

  task automatic load_type_regs(logic [4:0] tl, logic [63:0] lo, logic [63:0] hi);
    write_reg(CFG_EXP_TYPE_LEN, {59'd0, tl});
    write_reg(CFG_TYPE_LOW, lo);
    write_reg(CFG_TYPE_HIGH, hi);
    cfg_we <= 1'b0;
  endtask

  // Build a record that is mostly well formed: external TNF, the configured
  // type, a short payload. Now and then break the flags, the type length,
  // a type byte or the payload length, or cut the message short.
  function automatic void build_record(logic [4:0] want);
    logic [7:0]  fl;
    logic [7:0]  tl;
    logic [7:0]  idl;
    logic [7:0]  b;
    logic [31:0] pl;
    int unsigned r;
    int unsigned npay;
    int unsigned keep;
    rec_bytes.delete();

    r = $urandom_range(0, 99);
    fl[2:0]          = (r < 88) ? TNF_EXTERNAL[2:0] : 3'($urandom_range(0, 7));
    fl[7:5]          = 3'($urandom);
    fl[FLAG_SR_BIT]  = ($urandom_range(0, 9) < 6);
    fl[FLAG_IL_BIT]  = ($urandom_range(0, 9) < 3);
    rec_bytes.push_back(fl);

    r = $urandom_range(0, 99);
    if (r < 85) tl = 8'(want);
    else if (r < 97) tl = 8'($urandom_range(0, 20));
    else tl = 8'($urandom);
    rec_bytes.push_back(tl);

    r = $urandom_range(0, 99);
    if (r < 85) pl = $urandom_range(1, 12);
    else if (r < 90) pl = '0;
    else if (fl[FLAG_SR_BIT]) pl = $urandom_range(13, 255);
    else pl = $urandom;
    if (fl[FLAG_SR_BIT]) rec_bytes.push_back(pl[7:0]);
    else begin
      rec_bytes.push_back(pl[31:24]);
      rec_bytes.push_back(pl[23:16]);
      rec_bytes.push_back(pl[15:8]);
      rec_bytes.push_back(pl[7:0]);
    end

    if (fl[FLAG_IL_BIT]) begin
      r = $urandom_range(0, 99);
      if (r < 50) idl = 8'($urandom_range(1, 4));
      else if (r < 93) idl = 8'd0;
      else idl = 8'($urandom);
      rec_bytes.push_back(idl);
      repeat (idl) rec_bytes.push_back(8'($urandom));
    end

    // Type bytes past the register table are random; flip a bit now and then.
    for (int k = 0; k < tl; k++) begin
      b = (k < MAX_TYPE_BYTES) ? board.type_byte(k) : 8'($urandom);
      if ($urandom_range(0, 29) == 0) b = b ^ 8'(1 << $urandom_range(0, 7));
      rec_bytes.push_back(b);
    end

    npay = (pl > 12) ? $urandom_range(0, 12) : pl;
    if ($urandom_range(0, 4) == 0) npay += $urandom_range(1, 4);
    repeat (npay) rec_bytes.push_back(8'($urandom));

    if ($urandom_range(0, 9) == 0) begin
      keep = $urandom_range(1, rec_bytes.size());
      while (rec_bytes.size() > keep) void'(rec_bytes.pop_back());
    end
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [63:0] lo;
    logic [63:0] hi;
    logic [7:0]  t0;
    logic [7:0]  t1;
    logic [4:0]  want;
    int unsigned spent;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset registers expect a zero-length type: this record matches.
    rec_bytes = '{8'h14, 8'h00, 8'h01, 8'hAB};
    send_frame();
    settle();

    lo = {$urandom, $urandom};
    hi = {$urandom, $urandom};
    load_type_regs(5'd2, lo, hi);
    t0 = lo[7:0];
    t1 = lo[15:8];

    // Short form, matching.
    rec_bytes = '{8'hD4, 8'h02, 8'h02, t0, t1, 8'hFF, 8'h00};
    send_frame();
    // Long form with an empty ID field.
    rec_bytes = '{8'h0C, 8'h02, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, t0, t1, 8'h5A};
    send_frame();
    // Short form with two ID bytes to skip.
    rec_bytes = '{8'h1C, 8'h02, 8'h03, 8'h02, 8'hAA, 8'hBB, t0, t1, 8'h01, 8'h02, 8'h03};
    send_frame();
    // Wrong TNF.
    rec_bytes = '{8'h11, 8'h02, 8'h01, t0, t1, 8'h00};
    send_frame();
    // Zero payload length.
    rec_bytes = '{8'h14, 8'h02, 8'h00, t0, t1};
    send_frame();
    // Type mismatch in the last type byte.
    rec_bytes = '{8'h14, 8'h02, 8'h01, t0, ~t1, 8'h07};
    send_frame();
    // Messages too short for any header.
    rec_bytes = '{8'h14};
    send_frame();
    rec_bytes = '{8'h14, 8'h02};
    send_frame();
    // Payload length that would wrap a 32-bit sum.
    rec_bytes = '{8'h04, 8'h02, 8'hFF, 8'hFF, 8'hFF, 8'hFF, t0, t1, 8'h00};
    send_frame();
    // Type length that differs from the register.
    rec_bytes = '{8'h14, 8'h03, 8'h01, t0, t1, lo[23:16], 8'h42};
    send_frame();
    // Long form cut before the last length byte.
    rec_bytes = '{8'h04, 8'h02, 8'h00, 8'h00, 8'h00};
    send_frame();
    // ID flag set but the ID length byte is missing.
    rec_bytes = '{8'h1C, 8'h00, 8'h01};
    send_frame();

    // Random part: one register setting per phase, extremes included.
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      lo = {$urandom, $urandom};
      hi = {$urandom, $urandom};
      case (p)
        0: begin
          want = 5'd16;
          lo   = '1;
          hi   = '1;
        end
        1: begin
          want = 5'd0;
          lo   = '0;
          hi   = '0;
        end
        2: want = 5'd17;
        3: want = 5'd1;
        4: want = 5'd8;
        default: want = 5'($urandom_range(2, 15));
      endcase
      load_type_regs(want, lo, hi);

      spent = 0;
      while (spent < PHASE_BYTES) begin
        steady = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 9) == 0) begin
          // Noise: a few random bytes taken as a message.
          repeat ($urandom_range(1, 8)) rec_bytes.push_back(8'($urandom));
        end else begin
          build_record(want);
        end
        spent += rec_bytes.size();
        send_frame();
      end
    end

    settle();
    repeat (12) @(posedge clk);
    if (board.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
